### rtl/core/gcpd_pkg.sv
package gcpd_pkg;

    // Field widths
    localparam int LEVEL_W   = 8;
    localparam int THRESH_W  = 8;
    localparam int BITCNT_W  = 5;
    localparam int INDEX_W   = 16;
    localparam int POS_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Defaults
    localparam int DEF_MAX_BITS    = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [THRESH_W-1:0] SHADOW_THR_RST = 8'd8;
    localparam logic [THRESH_W-1:0] BIT_THR_RST    = 8'd1;
    localparam logic [BITCNT_W-1:0] BIT_COUNT_RST  = 5'd10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 2'd2;

    // Classified pair, front to back
    typedef struct packed {
        logic head;      // white/black pair opens a pixel
        logic lit;       // white - black above shadow threshold
        logic reliable;  // |pattern - inverse| above bit threshold
        logic gray;      // pattern brighter than inverse
        logic last;      // last bit pair of the pixel
    } gcpd_token_t;

    localparam int TOKEN_W = $bits(gcpd_token_t);

endpackage

### rtl/core/gcpd_front.sv
module gcpd_front import gcpd_pkg::*; #(
    parameter int MAX_BITS = DEF_MAX_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    input  logic                 in_fire,
    input  logic [LEVEL_W-1:0]   first_level,
    input  logic [LEVEL_W-1:0]   second_level,
    output gcpd_token_t          token
);

    logic [THRESH_W-1:0] shadow_thr_reg;
    logic [THRESH_W-1:0] bit_thr_reg;
    logic [BITCNT_W-1:0] bit_count_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [POS_W-1:0]    eff_bits;
    logic                brighter;
    logic [LEVEL_W-1:0]  abs_diff;

    // Saturate the plane count to one..MAX_BITS
    always_comb begin
        if (bit_count_reg == '0) begin
            eff_bits = POS_W'(1);
        end else if (POS_W'(bit_count_reg) > POS_W'(MAX_BITS)) begin
            eff_bits = POS_W'(MAX_BITS);
        end else begin
            eff_bits = POS_W'(bit_count_reg);
        end
    end

    assign brighter = first_level > second_level;
    assign abs_diff = brighter ? (first_level - second_level) : (second_level - first_level);

    always_comb begin
        token.head     = (pos_reg == '0);
        token.lit      = brighter && (abs_diff > shadow_thr_reg);
        token.reliable = abs_diff > bit_thr_reg;
        token.gray     = brighter;
        token.last     = (pos_reg != '0) && (pos_reg >= eff_bits);
    end

    always_comb begin
        pos_next = pos_reg;
        if (in_fire) begin
            pos_next = token.last ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shadow_thr_reg <= SHADOW_THR_RST;
            bit_thr_reg    <= BIT_THR_RST;
            bit_count_reg  <= BIT_COUNT_RST;
            pos_reg        <= '0;
        end else begin
            pos_reg <= pos_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_SHADOW_THR: shadow_thr_reg <= cfg_wr_data;
                    REG_BIT_THR:    bit_thr_reg    <= cfg_wr_data;
                    REG_BIT_COUNT:  bit_count_reg  <= cfg_wr_data[BITCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### rtl/core/gcpd_fifo.sv
module gcpd_fifo import gcpd_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  gcpd_token_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output gcpd_token_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gcpd_token_t       mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

### rtl/core/gcpd_back.sv
module gcpd_back import gcpd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tok_valid,
    input  gcpd_token_t        tok,
    output logic               tok_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               pixel_lit,
    output logic               decoded,
    output logic [INDEX_W-1:0] column_index
);

    logic               lit_reg;
    logic               rel_reg;
    logic               prev_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic               out_valid_reg;
    logic               out_lit_reg;
    logic               out_dec_reg;
    logic [INDEX_W-1:0] out_idx_reg;

    logic               out_free;
    logic               bin_bit;
    logic               rel_next;
    logic [INDEX_W-1:0] idx_next;
    logic               ok;

    assign out_free = !out_valid_reg || out_ready;
    assign tok_pop  = tok_valid && (!tok.last || out_free);

    assign bin_bit  = tok.gray ^ prev_reg;
    assign rel_next = rel_reg && tok.reliable;
    assign idx_next = {idx_reg[INDEX_W-2:0], bin_bit};
    assign ok       = lit_reg && rel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg       <= 1'b0;
            rel_reg       <= 1'b1;
            prev_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (tok_pop && !tok.head && tok.last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (tok_pop) begin
                if (tok.head) begin
                    // open a new pixel
                    lit_reg  <= tok.lit;
                    rel_reg  <= 1'b1;
                    prev_reg <= 1'b0;
                    idx_reg  <= '0;
                end else begin
                    rel_reg  <= rel_next;
                    prev_reg <= bin_bit;
                    idx_reg  <= idx_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_pop && !tok.head && tok.last) begin
            out_lit_reg <= lit_reg;
            out_dec_reg <= ok;
            out_idx_reg <= ok ? idx_next : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_lit    = out_lit_reg;
    assign decoded      = out_dec_reg;
    assign column_index = out_idx_reg;

endmodule

### rtl/core/gray_code_pattern_pixel_decoder.sv
// Structured-light Gray-code decoder, one camera pixel per run of requests.
//
// Input stream (s_): one request per intensity pair. The first request of a
// pixel carries white/black; the next bit_count requests carry pattern/inverse,
// most significant plane first. Output stream (m_): one request per pixel,
// issued after its last pair, with the lit flag, the decoded flag and the
// Gray-decoded column index (zero unless decoded).
//
// Throughput: one pair per cycle while the token queue has room, independent of
// bit_count; s_tready drops once a result waits at m_tready low and the queue fills.
// After the last pair is accepted it passes through the token queue, then the back
// end loads the output register and raises m_tvalid; the result is taken at the
// first edge with m_tready high.
// Reset (aresetn low, synchronous) restores the register defaults, empties
// the token queue and expects a white/black pair next.
// When m_tready is low the result holds in the output register; the queue
// keeps taking pairs until it fills, then s_tready drops.
// Configuration writes are taken at any edge with cfg_wr_en high and should
// be issued only while no pixel is in flight.
module gray_code_pattern_pixel_decoder import gcpd_pkg::*; #(
    parameter int MAX_BITS    = DEF_MAX_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Register write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,

    // Intensity pairs
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [7:0] first_level, [15:8] second_level

    // Pixel results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] column_index
    output logic [1:0]           m_tuser    // [0] pixel_lit, [1] decoded
);

    gcpd_token_t front_tok;
    gcpd_token_t queue_tok;
    logic        in_fire;
    logic        queue_full;
    logic        queue_valid;
    logic        queue_pop;
    logic        res_lit;
    logic        res_dec;

    // Accept a pair whenever the queue has room
    assign s_tready = !queue_full;
    assign in_fire  = s_tvalid && s_tready;

    // Classify: position in the pixel, compares against thresholds
    gcpd_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_fire      (in_fire),
        .first_level  (s_tdata[LEVEL_W-1:0]),
        .second_level (s_tdata[2*LEVEL_W-1:LEVEL_W]),
        .token        (front_tok)
    );

    // Decouple classify from accumulate
    gcpd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (front_tok),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_data  (queue_tok)
    );

    // Accumulate Gray bits, issue one result per pixel
    gcpd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tok_valid    (queue_valid),
        .tok          (queue_tok),
        .tok_pop      (queue_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_lit    (res_lit),
        .decoded      (res_dec),
        .column_index (m_tdata)
    );

    assign m_tuser = {res_dec, res_lit};

endmodule
